// ===== hw/rtl/gcc_pkg.sv =====
package gcc_pkg;

    // Field widths fixed by the interface
    localparam int COIN_BITS     = 16;
    localparam int SLOT_BITS     = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int QTY_BITS      = 16;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_COINS   = 6;
    localparam int DEF_AMOUNT_BITS = 16;

    // Register map
    localparam int REG_SLOTS = 6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COIN_0       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COIN_1       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COIN_2       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COIN_3       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COIN_4       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COIN_5       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COINS_IN_USE = 3'd6;

    // Reset values
    localparam logic [SLOT_BITS-1:0] COINS_IN_USE_RESET = 3'd6;
    localparam logic [COIN_BITS-1:0] COIN_RESET [REG_SLOTS] = '{
        16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5
    };

endpackage

// ===== hw/rtl/greedy_coin_change.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_change_amount
// result    out        o_out_valid / i_out_stall  o_coin_slot, o_coin_quantity,
//                                                 o_amount_invalid, o_last_of_run
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Datapath: one bit-serial restoring divider yields one quotient bit per cycle.
// An amount takes one check division by the smallest coin, then one division
// per coin in use, AMOUNT_BITS quotient bits each; every coin's result is
// handed over to the output register through S_PUT.
// An amount of zero, or a zero smallest coin, is reported invalid without dividing.
// Reset: synchronous, active low; restores the denominations and coin count.
// Stalls: a held result stops the divider; the last result of a run may wait
// in the output register while the next amount is accepted.
module greedy_coin_change #(
    parameter int MAX_COINS   = gcc_pkg::DEF_MAX_COINS,
    parameter int AMOUNT_BITS = gcc_pkg::DEF_AMOUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [15:0]                    i_change_amount,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [gcc_pkg::SLOT_BITS-1:0]  o_coin_slot,
    output logic [gcc_pkg::QTY_BITS-1:0]   o_coin_quantity,
    output logic                           o_amount_invalid,
    output logic                           o_last_of_run,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gcc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [gcc_pkg::COIN_BITS-1:0]  i_cfg_data
);
    import gcc_pkg::*;

    // Width wide enough for both the amount and a 16-bit field
    localparam int WIDE_BITS = (AMOUNT_BITS > COIN_BITS) ? AMOUNT_BITS : COIN_BITS;
    localparam int CNT_BITS  = $clog2(AMOUNT_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_PUT
    } t_state;

    // ---------------------------------------------------------------
    // Configuration registers: always ready, ignore unmapped indexes
    // ---------------------------------------------------------------
    logic [COIN_BITS-1:0] r_coin [MAX_COINS];
    logic [SLOT_BITS-1:0] r_coins_in_use;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_COINS; i++) begin
                r_coin[i] <= COIN_RESET[i];
            end
            r_coins_in_use <= COINS_IN_USE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            for (int i = 0; i < MAX_COINS; i++) begin
                if (i_cfg_index == CFG_IDX_BITS'(i)) begin
                    r_coin[i] <= i_cfg_data;
                end
            end
            if (i_cfg_index == CFG_COINS_IN_USE) begin
                r_coins_in_use <= i_cfg_data[SLOT_BITS-1:0];
            end
        end
    end

    // Clamp the coin count into 1..MAX_COINS; the last slot holds the smallest
    logic [SLOT_BITS-1:0] last_slot;

    always_comb begin
        priority if (r_coins_in_use == '0) begin
            last_slot = '0;
        end else if (r_coins_in_use > SLOT_BITS'(MAX_COINS)) begin
            last_slot = SLOT_BITS'(MAX_COINS - 1);
        end else begin
            last_slot = r_coins_in_use - SLOT_BITS'(1);
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    t_state                 r_state;
    logic [SLOT_BITS-1:0]   r_slot;      // coin under division
    logic [AMOUNT_BITS-1:0] r_rem;       // amount still to split
    logic [AMOUNT_BITS-1:0] r_quo;       // dividend in, quotient out
    logic [COIN_BITS-1:0]   r_part;      // partial remainder
    logic [COIN_BITS-1:0]   r_div;       // divisor
    logic [CNT_BITS-1:0]    r_cnt;       // quotient bit count

    // Result waiting for the output register
    logic [SLOT_BITS-1:0]   r_pend_slot;
    logic [QTY_BITS-1:0]    r_pend_qty;
    logic                   r_pend_inv;
    logic                   r_pend_last;

    // Coin selects for the smallest coin and the next slot
    logic [SLOT_BITS-1:0]   slot_inc;
    logic [COIN_BITS-1:0]   coin_smallest;
    logic [COIN_BITS-1:0]   coin_next;

    assign slot_inc = r_slot + SLOT_BITS'(1);

    always_comb begin
        coin_smallest = '0;
        coin_next     = '0;
        for (int i = 0; i < MAX_COINS; i++) begin
            if (last_slot == SLOT_BITS'(i)) begin
                coin_smallest = r_coin[i];
            end
            if (slot_inc == SLOT_BITS'(i)) begin
                coin_next = r_coin[i];
            end
        end
    end

    // Incoming amount, masked to AMOUNT_BITS
    logic [WIDE_BITS-1:0]   amount_wide;
    logic [AMOUNT_BITS-1:0] amount;

    assign amount_wide = WIDE_BITS'(i_change_amount);
    assign amount      = amount_wide[AMOUNT_BITS-1:0];

    // One restoring step: shift in the next dividend bit, subtract if it fits
    logic [COIN_BITS:0]     shifted;
    logic [COIN_BITS:0]     diff;
    logic                   fits;
    logic [COIN_BITS-1:0]   n_part;
    logic [AMOUNT_BITS-1:0] n_quo;
    logic                   step_done;

    assign shifted   = {r_part, r_quo[AMOUNT_BITS-1]};
    assign diff      = shifted - {1'b0, r_div};
    assign fits      = !diff[COIN_BITS];
    assign n_part    = fits ? diff[COIN_BITS-1:0] : shifted[COIN_BITS-1:0];
    assign step_done = (r_cnt == CNT_BITS'(AMOUNT_BITS - 1));

    generate
        if (AMOUNT_BITS > 1) begin : g_quo
            assign n_quo = {r_quo[AMOUNT_BITS-2:0], fits};
        end else begin : g_quo1
            assign n_quo = fits;
        end
    endgenerate

    // Quotient saturated to the quantity field; remainder resized to the amount
    logic [WIDE_BITS-1:0]   quo_wide;
    logic [QTY_BITS-1:0]    qty_sat;
    logic [WIDE_BITS-1:0]   part_wide;

    assign quo_wide  = WIDE_BITS'(n_quo);
    assign qty_sat   = (quo_wide > WIDE_BITS'({QTY_BITS{1'b1}})) ? {QTY_BITS{1'b1}}
                                                                : quo_wide[QTY_BITS-1:0];
    assign part_wide = WIDE_BITS'(n_part);

    logic out_taken;

    assign out_taken  = o_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // ---------------------------------------------------------------
    // Sequencer and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            // drop the result once the far side has taken it, unless the
            // hand-over below refills the register in the same cycle
            if (out_taken && r_state != S_PUT) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rem  <= amount;
                        r_quo  <= amount;
                        r_part <= '0;
                        r_div  <= coin_smallest;
                        r_cnt  <= '0;
                        r_slot <= '0;
                        if (amount == '0 || coin_smallest == '0) begin
                            // invalid without dividing
                            r_pend_slot <= '0;
                            r_pend_qty  <= '0;
                            r_pend_inv  <= 1'b1;
                            r_pend_last <= 1'b1;
                            r_state     <= S_PUT;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end

                S_CHECK: begin
                    // amount modulo smallest coin must be zero
                    if (!step_done) begin
                        r_quo  <= n_quo;
                        r_part <= n_part;
                        r_cnt  <= r_cnt + CNT_BITS'(1);
                    end else if (n_part != '0) begin
                        r_pend_slot <= '0;
                        r_pend_qty  <= '0;
                        r_pend_inv  <= 1'b1;
                        r_pend_last <= 1'b1;
                        r_state     <= S_PUT;
                    end else begin
                        // start the greedy run at the largest coin
                        r_quo   <= r_rem;
                        r_part  <= '0;
                        r_div   <= r_coin[0];
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    if (r_div == '0) begin
                        // a zero coin gives nothing; the remainder passes on
                        r_pend_slot <= r_slot;
                        r_pend_qty  <= '0;
                        r_pend_inv  <= 1'b0;
                        r_pend_last <= (r_slot == last_slot);
                        r_state     <= S_PUT;
                    end else begin
                        r_quo  <= n_quo;
                        r_part <= n_part;
                        r_cnt  <= r_cnt + CNT_BITS'(1);
                        if (step_done) begin
                            r_rem       <= part_wide[AMOUNT_BITS-1:0];
                            r_pend_slot <= r_slot;
                            r_pend_qty  <= qty_sat;
                            r_pend_inv  <= 1'b0;
                            r_pend_last <= (r_slot == last_slot);
                            r_state     <= S_PUT;
                        end
                    end
                end

                S_PUT: begin
                    // hold until the output register is free
                    if (!o_out_valid || out_taken) begin
                        o_out_valid      <= 1'b1;
                        o_coin_slot      <= r_pend_slot;
                        o_coin_quantity  <= r_pend_qty;
                        o_amount_invalid <= r_pend_inv;
                        o_last_of_run    <= r_pend_last;
                        if (r_pend_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            // advance to the next coin with the remainder
                            r_slot  <= slot_inc;
                            r_quo   <= r_rem;
                            r_part  <= '0;
                            r_div   <= coin_next;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_invalid_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_amount_invalid |->
            o_last_of_run && o_coin_slot == '0 && o_coin_quantity == '0)
        else $error("invalid result is not a lone zero result");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_amount_invalid && o_last_of_run |-> o_coin_slot == last_slot)
        else $error("run ended on the wrong coin slot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted a second amount while the first is in progress");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_slot <= last_slot)
        else $error("division ran past the last coin in use");

endmodule
